>>> sv/twma_pkg.sv
// ----------------------------------------------------------------------------
// twma_pkg
// Shared constants and controller/datapath interface types for the
// time weighted moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package twma_pkg;

  localparam int DEF_MAX_WINDOW = 255;
  localparam int DEF_VALUE_BITS = 16;
  localparam int DEF_TIME_BITS  = 32;

  localparam int ACC_BITS     = 64;
  localparam int CFG_BITS     = 8;
  localparam int MIN_WINDOW   = 2;
  localparam int WINDOW_RESET = 2;

  // commands from the controller, at most one active per cycle
  typedef struct packed {
    logic capture;
    logic start;
    logic rd_a;
    logic rd_b;
    logic lat_b;
    logic mul_old;
    logic sub_old;
    logic mul_new;
    logic add_new;
    logic mag;
    logic check;
    logic div_step;
    logic writeback;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic full;
    logic need_div;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> sv/twma_ctrl.sv
// ----------------------------------------------------------------------------
// twma_ctrl
// Sequencer for one sample: window retire, new segment, divide, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module twma_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire twma_pkg::status_t st,
  output twma_pkg::cmd_t        cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_START   = 14'b00000000000010,
    S_RD_A    = 14'b00000000000100,
    S_RD_B    = 14'b00000000001000,
    S_LAT_B   = 14'b00000000010000,
    S_MUL_OLD = 14'b00000000100000,
    S_SUB_OLD = 14'b00000001000000,
    S_MUL_NEW = 14'b00000010000000,
    S_ADD_NEW = 14'b00000100000000,
    S_MAG     = 14'b00001000000000,
    S_CHECK   = 14'b00010000000000,
    S_DIV     = 14'b00100000000000,
    S_WB      = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (st.start) begin
            state_next = S_START;
          end else if (st.full) begin
            state_next = S_RD_A;
          end else begin
            state_next = S_MUL_NEW;
          end
        end
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_WB;
      end
      S_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = S_LAT_B;
      end
      S_LAT_B: begin
        cmd.lat_b  = 1'b1;
        state_next = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        cmd.mul_old = 1'b1;
        state_next  = S_SUB_OLD;
      end
      S_SUB_OLD: begin
        cmd.sub_old = 1'b1;
        state_next  = S_MUL_NEW;
      end
      S_MUL_NEW: begin
        cmd.mul_new = 1'b1;
        state_next  = S_ADD_NEW;
      end
      S_ADD_NEW: begin
        cmd.add_new = 1'b1;
        state_next  = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.need_div ? S_DIV : S_WB;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.writeback = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/twma_datapath.sv
// ----------------------------------------------------------------------------
// twma_datapath
// History ring, area accumulator, shared multiplier, restoring divider and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module twma_datapath #(
  parameter int MAX_WINDOW = twma_pkg::DEF_MAX_WINDOW,
  parameter int VALUE_BITS = twma_pkg::DEF_VALUE_BITS,
  parameter int TIME_BITS  = twma_pkg::DEF_TIME_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [twma_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  wire logic [TIME_BITS-1:0]                sample_time,
  input  wire logic signed [VALUE_BITS-1:0]        sample_value,
  input  wire logic                                first_sample,
  input  wire logic                                last_sample,
  input  wire twma_pkg::cmd_t                      cmd,
  output twma_pkg::status_t                        st,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [TIME_BITS-1:0]                     out_time,
  output logic signed [VALUE_BITS-1:0]             out_value,
  output logic                                     zero_span,
  output logic                                     end_of_record
);

  localparam int DEPTH    = MAX_WINDOW + 1;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
  localparam int KB       = PTR_BITS + 1;
  localparam int VB       = VALUE_BITS;
  localparam int TB       = TIME_BITS;
  localparam int AB       = twma_pkg::ACC_BITS;
  localparam int PW       = VB + TB + 2;
  localparam int QB       = VB - 1;
  localparam int CNT_BITS = $clog2(QB);

  // configuration and record state
  logic [twma_pkg::CFG_BITS-1:0] window_segments;
  logic [WIN_BITS-1:0]           active_window;
  logic [WIN_BITS-1:0]           seg_count;
  logic [PTR_BITS-1:0]           ptr;
  logic [TB-1:0]                 rec_start;
  logic                          in_record;
  logic [AB-1:0]                 acc;

  // captured transaction
  logic [TB-1:0]        t_in;
  logic signed [VB-1:0] v_in;
  logic                 last_in;

  // previous sample kept outside the ring
  logic [TB-1:0]        prev_time;
  logic signed [VB-1:0] prev_value;

  // ring
  logic [TB+VB-1:0]     ring [DEPTH];
  logic [TB+VB-1:0]     rd_data;
  logic [PTR_BITS-1:0]  rd_addr;
  logic [PTR_BITS-1:0]  slot_a;
  logic [PTR_BITS-1:0]  slot_b;
  logic [KB-1:0]        k_b;

  logic [TB-1:0]        a_time;
  logic signed [VB-1:0] a_value;
  logic [TB-1:0]        b_time;
  logic signed [VB-1:0] b_value;

  // multiplier
  logic signed [VB-1:0] mul_va;
  logic signed [VB-1:0] mul_vb;
  logic [TB-1:0]        mul_dt;
  logic signed [VB:0]   mul_sum;
  logic signed [PW-1:0] mul_res;
  logic signed [PW-1:0] prod;
  logic [AB-1:0]        prod_ext;

  // window and divide
  logic [TB-1:0]        wstart;
  logic [TB-1:0]        wsel;
  logic [TB-1:0]        span;
  logic [TB:0]          divisor;
  logic                 neg;
  logic [AB-1:0]        mag;
  logic [AB-1:0]        mag_hi;
  logic                 span_is_zero;
  logic                 saturate;
  logic [TB:0]          rem;
  logic [QB-1:0]        dlow;
  logic [QB-2:0]        quo;
  logic [CNT_BITS-1:0]  div_cnt;
  logic [TB+1:0]        trial;
  logic [TB+1:0]        trial_diff;
  logic                 ge;
  logic [QB-1:0]        q_final;
  logic [VB-1:0]        q_ext;
  logic                 full;
  logic [WIN_BITS-1:0]  window_clamped;

  // result
  logic [TB-1:0]        res_time;
  logic signed [VB-1:0] res_value;
  logic                 res_zspan;

  function automatic logic [PTR_BITS-1:0] slot_back(input logic [PTR_BITS-1:0] p,
                                                    input logic [KB-1:0]       k);
    logic [KB-1:0] pe;
    logic [KB-1:0] d;
    pe = {1'b0, p};
    if (pe >= k) begin
      d = pe - k;
    end else begin
      d = pe + KB'(DEPTH) - k;
    end
    return d[PTR_BITS-1:0];
  endfunction

  always_comb begin
    if (window_segments < twma_pkg::CFG_BITS'(twma_pkg::MIN_WINDOW)) begin
      window_clamped = WIN_BITS'(twma_pkg::MIN_WINDOW);
    end else if (32'(window_segments) > MAX_WINDOW) begin
      window_clamped = WIN_BITS'(MAX_WINDOW);
    end else begin
      window_clamped = WIN_BITS'(window_segments);
    end
  end

  assign full   = (seg_count >= active_window);
  assign k_b    = {1'b0, active_window};
  assign slot_b = slot_back(ptr, k_b);
  assign slot_a = slot_back(ptr, k_b + KB'(1));
  assign rd_addr = cmd.rd_a ? slot_a : slot_b;

  // segment leaving the window, or the newest one
  always_comb begin
    if (cmd.mul_old) begin
      mul_va = a_value;
      mul_vb = b_value;
      mul_dt = b_time - a_time;
    end else begin
      mul_va = prev_value;
      mul_vb = v_in;
      mul_dt = t_in - prev_time;
    end
  end

  assign mul_sum  = {mul_va[VB-1], mul_va} + {mul_vb[VB-1], mul_vb};
  assign mul_res  = PW'(mul_sum) * $signed({1'b0, mul_dt});
  assign prod_ext = {{(AB-PW){prod[PW-1]}}, prod};

  assign wsel         = full ? b_time : rec_start;
  assign divisor      = {span, 1'b0};
  assign mag_hi       = mag >> (VB - 1);
  assign span_is_zero = (span == '0);
  assign saturate     = (mag_hi >= AB'(divisor));

  assign trial      = {rem, dlow[QB-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign ge         = (trial >= {1'b0, divisor});
  assign q_final    = {quo, ge};
  assign q_ext      = {1'b0, q_final};

  assign st.start    = first_sample | ~in_record;
  assign st.full     = full;
  assign st.need_div = ~span_is_zero & ~saturate;
  assign st.div_last = (div_cnt == CNT_BITS'(QB - 1));
  assign st.out_busy = out_valid & ~out_ready;

  // ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.writeback) begin
      ring[ptr] <= {t_in, v_in};
    end
    rd_data <= ring[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_segments <= twma_pkg::CFG_BITS'(twma_pkg::WINDOW_RESET);
      active_window   <= WIN_BITS'(twma_pkg::WINDOW_RESET);
      seg_count       <= '0;
      ptr             <= '0;
      rec_start       <= '0;
      in_record       <= 1'b0;
      acc             <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_segments <= cfg_wdata;
      end
      if (cmd.start) begin
        active_window <= window_clamped;
        seg_count     <= '0;
        rec_start     <= t_in;
        acc           <= '0;
      end
      if (cmd.sub_old) begin
        acc <= acc - prod_ext;
      end
      if (cmd.add_new) begin
        acc <= acc + prod_ext;
        if (!full) begin
          seg_count <= seg_count + WIN_BITS'(1);
        end
      end
      if (cmd.writeback) begin
        ptr       <= (ptr == PTR_BITS'(DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
        in_record <= ~last_in;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_in    <= sample_time;
      v_in    <= sample_value;
      last_in <= last_sample;
    end
    if (cmd.rd_b) begin
      a_time  <= rd_data[TB+VB-1:VB];
      a_value <= rd_data[VB-1:0];
    end
    if (cmd.lat_b) begin
      b_time  <= rd_data[TB+VB-1:VB];
      b_value <= rd_data[VB-1:0];
    end
    if (cmd.mul_old || cmd.mul_new) begin
      prod <= mul_res;
    end
    if (cmd.start) begin
      res_time  <= t_in;
      res_value <= v_in;
      res_zspan <= 1'b0;
    end
    if (cmd.add_new) begin
      wstart <= wsel;
      span   <= t_in - wsel;
    end
    if (cmd.mag) begin
      neg      <= acc[AB-1];
      mag      <= acc[AB-1] ? (~acc + AB'(1)) : acc;
      res_time <= wstart + (span >> 1);
    end
    if (cmd.check) begin
      res_zspan <= span_is_zero;
      if (span_is_zero) begin
        res_value <= '0;
      end else if (saturate) begin
        res_value <= neg ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
      end
      // remainder starts below the divisor, so only QB quotient bits remain
      rem     <= mag_hi[TB:0];
      dlow    <= mag[QB-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= ge ? trial_diff[TB:0] : trial[TB:0];
      dlow    <= dlow << 1;
      quo     <= q_final[QB-2:0];
      div_cnt <= div_cnt + CNT_BITS'(1);
      if (st.div_last) begin
        res_value <= neg ? -q_ext : q_ext;
      end
    end
    if (cmd.writeback) begin
      prev_time  <= t_in;
      prev_value <= v_in;
    end
    if (cmd.out_load) begin
      out_time      <= res_time;
      out_value     <= res_value;
      zero_span     <= res_zspan;
      end_of_record <= last_in;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a pending transaction");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= active_window)
    else $error("segment count beyond window");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    (active_window >= WIN_BITS'(twma_pkg::MIN_WINDOW)) &&
    (active_window <= WIN_BITS'(MAX_WINDOW)))
    else $error("active window out of range");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_span) |-> (out_value == '0))
    else $error("zero span with nonzero value");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < divisor))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> sv/time_weighted_moving_average_top.sv
// ----------------------------------------------------------------------------
// time_weighted_moving_average_top
// Trapezoidal moving average over nonuniformly timed samples.
// ----------------------------------------------------------------------------
// One result per input transaction. The first sample of a record goes
// straight from start to write back. Other samples add the new segment,
// take the magnitude and divide while the window is still growing, and
// once it is full the oldest segment is first fetched from the history
// ring in two registered reads and retired through the shared multiplier.
// The restoring divider produces one quotient bit per cycle; a zero span
// or a saturated average skips it. The input is ready again in the cycle
// after a result is loaded. A new sample is taken once the previous one
// has reached the output register, which frees the input side even while
// the result waits. The ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module time_weighted_moving_average_top #(
  parameter int MAX_WINDOW = twma_pkg::DEF_MAX_WINDOW,
  parameter int VALUE_BITS = twma_pkg::DEF_VALUE_BITS,
  parameter int TIME_BITS  = twma_pkg::DEF_TIME_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [twma_pkg::CFG_BITS-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [TIME_BITS-1:0]          sample_time,
  input  wire logic signed [VALUE_BITS-1:0]  sample_value,
  input  wire logic                          first_sample,
  input  wire logic                          last_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [TIME_BITS-1:0]               out_time,
  output logic signed [VALUE_BITS-1:0]       out_value,
  output logic                               zero_span,
  output logic                               end_of_record
);

  twma_pkg::cmd_t    cmd;
  twma_pkg::status_t st;

  twma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  twma_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .VALUE_BITS (VALUE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .sample_time   (sample_time),
    .sample_value  (sample_value),
    .first_sample  (first_sample),
    .last_sample   (last_sample),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_time      (out_time),
    .out_value     (out_value),
    .zero_span     (zero_span),
    .end_of_record (end_of_record)
  );

endmodule

`default_nettype wire
